// ===== rtl/hsrn_pkg.sv =====
// Shared types and constants for the five-point stencil residual norm block.
// No dependencies; imported by every module of the block.
package hsrn_pkg;

  localparam int DATA_W      = 32;  // Q16.16 sample width
  localparam int VALUE_WIDTH = 32;  // saturation width of one residual
  localparam int SUM_W       = 64;  // Q48.16 accumulator width
  localparam int CFG_IDX_W   = 2;
  localparam int SIDE_W      = 11;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIAG_COEFF = 2'd1;

  localparam logic [SIDE_W-1:0] GRID_SIDE_RST  = 11'd3;
  localparam logic [DATA_W-1:0] DIAG_COEFF_RST = 32'd262144;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ2,
    ST_SUM,
    ST_RES,
    ST_SQUARE,
    ST_ACC
  } state_e;

  // Stage strobes from the sequencer to the arithmetic path
  typedef struct packed {
    logic ld_first;
    logic ld_sum;
    logic ld_res;
    logic ld_sq;
    logic acc_en;
    logic acc_clr;
    logic interior;
  } stage_ctrl_t;

endpackage

// ===== rtl/hsrn_line_store.sv =====
// Line buffers: two rows of u (two read ports) and one row of b (one read port).
// Depends on hsrn_pkg; registered (synchronous) read, read-old on collision.
module hsrn_line_store #(
  parameter int CW = 10
) (
  input  logic                      clk_i,
  input  logic [CW:0]               u_addr_a_i,
  input  logic [CW:0]               u_addr_b_i,
  input  logic [CW-1:0]             b_addr_i,
  input  logic                      we_i,
  input  logic [CW:0]               u_waddr_i,
  input  logic [CW-1:0]             b_waddr_i,
  input  logic [hsrn_pkg::DATA_W-1:0] u_wdata_i,
  input  logic [hsrn_pkg::DATA_W-1:0] b_wdata_i,
  output logic [hsrn_pkg::DATA_W-1:0] u_rdata_a_o,
  output logic [hsrn_pkg::DATA_W-1:0] u_rdata_b_o,
  output logic [hsrn_pkg::DATA_W-1:0] b_rdata_o
);
  import hsrn_pkg::*;

  localparam int U_DEPTH = 2 ** (CW + 1);
  localparam int B_DEPTH = 2 ** CW;

  logic [DATA_W-1:0] u_mem [U_DEPTH];
  logic [DATA_W-1:0] b_mem [B_DEPTH];

  always_ff @(posedge clk_i) begin
    u_rdata_a_o <= u_mem[u_addr_a_i];
    u_rdata_b_o <= u_mem[u_addr_b_i];
    if (we_i) begin
      u_mem[u_waddr_i] <= u_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    b_rdata_o <= b_mem[b_addr_i];
    if (we_i) begin
      b_mem[b_waddr_i] <= b_wdata_i;
    end
  end

endmodule

// ===== rtl/hsrn_residual.sv =====
// Arithmetic path: stencil sum, centre product, rounding, saturation, square, accumulate.
// Depends on hsrn_pkg; stage loads come from the sequencer in the top level.
module hsrn_residual (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hsrn_pkg::stage_ctrl_t       ctrl_i,
  input  logic [hsrn_pkg::DATA_W-1:0] diag_i,
  input  logic [hsrn_pkg::DATA_W-1:0] down_i,
  input  logic [hsrn_pkg::DATA_W-1:0] centre_rd_i,
  input  logic [hsrn_pkg::DATA_W-1:0] up_rd_i,
  input  logic [hsrn_pkg::DATA_W-1:0] b_rd_i,
  input  logic [hsrn_pkg::DATA_W-1:0] left_rd_i,
  input  logic [hsrn_pkg::DATA_W-1:0] right_rd_i,
  output logic [hsrn_pkg::SUM_W-1:0]  acc_next_o
);
  import hsrn_pkg::*;

  localparam int S5_W   = DATA_W + 3;
  localparam int PROD_W = 2 * DATA_W;
  localparam int WIDE_W = PROD_W + 1;
  localparam int RND_W  = WIDE_W - 16;
  localparam logic signed [RND_W-1:0] RES_MAX = RND_W'((64'sd1 <<< (VALUE_WIDTH - 1)) - 1);
  localparam logic signed [RND_W-1:0] RES_MIN = -RES_MAX - RND_W'(1);

  logic signed [DATA_W-1:0] centre_q, up_q, bup_q;
  logic signed [S5_W-1:0]   sum5_q, sum5_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [DATA_W-1:0] res_q, res_d;
  logic [SUM_W-1:0]         sq_q, sq_d;
  logic [SUM_W-1:0]         acc_q;

  logic signed [WIDE_W-1:0] wide;
  logic signed [RND_W-1:0]  rnd;
  logic [DATA_W-1:0]        mag;
  logic [PROD_W-1:0]        sq_full;
  logic [SUM_W:0]           acc_sum;

  always_comb begin
    sum5_d = S5_W'($signed(bup_q)) + S5_W'($signed(up_q)) + S5_W'($signed(down_i))
           + S5_W'($signed(left_rd_i)) + S5_W'($signed(right_rd_i));
    prod_d = $signed(diag_i) * centre_q;
  end

  // Q33.32 residual, add half an LSB, floor back to Q16.16
  always_comb begin
    wide = (WIDE_W'(sum5_q) <<< 16) - WIDE_W'(prod_q) + WIDE_W'(32768);
    rnd  = wide[WIDE_W-1:16];
    if (rnd > RES_MAX) begin
      res_d = DATA_W'(RES_MAX);
    end else if (rnd < RES_MIN) begin
      res_d = DATA_W'(RES_MIN);
    end else begin
      res_d = rnd[DATA_W-1:0];
    end
  end

  always_comb begin
    mag     = res_q[DATA_W-1] ? DATA_W'(-res_q) : DATA_W'(res_q);
    sq_full = PROD_W'(mag) * PROD_W'(mag);
    sq_d    = SUM_W'(sq_full >> 16);
  end

  always_comb begin
    acc_sum = {1'b0, acc_q} + {1'b0, sq_q};
    if (!ctrl_i.interior) begin
      acc_next_o = acc_q;
    end else if (acc_sum[SUM_W]) begin
      acc_next_o = '1;
    end else begin
      acc_next_o = acc_sum[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_first) begin
      centre_q <= centre_rd_i;
      up_q     <= up_rd_i;
      bup_q    <= b_rd_i;
    end
    if (ctrl_i.ld_sum) begin
      sum5_q <= sum5_d;
      prod_q <= prod_d;
    end
    if (ctrl_i.ld_res) begin
      res_q <= res_d;
    end
    if (ctrl_i.ld_sq) begin
      sq_q <= sq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= ctrl_i.acc_clr ? '0 : acc_next_o;
    end
  end

endmodule

// ===== rtl/helmholtz_stencil_residual_norm.sv =====
// Five-point Helmholtz stencil residual norm over a raster-ordered square grid.
// Depends on hsrn_pkg, hsrn_line_store and hsrn_residual.
//
// Usage:
//   Grid points enter on the in channel (valid/ready), one item per point in
//   row-major order, each carrying u_value and b_value in signed Q16.16.
//   After the last point of a grid one item leaves on the out channel: the
//   saturating sum of squared interior residuals, unsigned Q48.16. The sum
//   then clears for the next grid.
//   A point is taken only when the sequencer is back in ST_IDLE, so the last
//   one is through first; per item it reads the line store twice (centre and
//   three u neighbours over two dual-port reads), writes it back, then rounds,
//   squares and accumulates in one pass. The result of a grid is loaded into
//   the output register in ST_ACC of its last point, so input keeps flowing
//   while the receiver stalls; only the last point of a following grid waits
//   for it. Configuration (grid_side, diag_coeff) is written through cfg_we_i
//   while the block is idle; the user must keep to this, the block does not
//   enforce it. Reset clears position, sum and output valid, and sets
//   grid_side to 3 and diag_coeff to 4.0; the line store needs no clearing.
module helmholtz_stencil_residual_norm #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hsrn_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [hsrn_pkg::DATA_W-1:0]    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [hsrn_pkg::DATA_W-1:0]    u_value_i,
  input  logic [hsrn_pkg::DATA_W-1:0]    b_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [hsrn_pkg::SUM_W-1:0]     l2_sum_o
);
  import hsrn_pkg::*;

  localparam int CW = $clog2(MAX_SIDE);
  localparam int SW = $clog2(MAX_SIDE + 1);

  state_e state_q, state_d;

  logic [SIDE_W-1:0] grid_side_q;
  logic [DATA_W-1:0] diag_q;
  logic [CW-1:0]     row_q, row_d, col_q, col_d;
  logic [SW-1:0]     side_n;
  logic              col_wrap, interior_d, last_d;

  logic [DATA_W-1:0] u_q, b_q;
  logic [CW-1:0]     col_cur_q;
  logic              par_q, interior_q, last_q;

  logic              out_valid_q;
  logic [SUM_W-1:0]  l2_sum_q;

  logic              accept, acc_stall, out_load;
  stage_ctrl_t       ctrl;
  logic              mem_we;
  logic [CW:0]       u_addr_a, u_addr_b;
  logic [CW-1:0]     b_addr;
  logic [DATA_W-1:0] u_rd_a, u_rd_b, b_rd;
  logic [SUM_W-1:0]  acc_next;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q <= GRID_SIDE_RST;
      diag_q      <= DIAG_COEFF_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GRID_SIDE:  grid_side_q <= cfg_wdata_i[SIDE_W-1:0];
        REG_DIAG_COEFF: diag_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_side_q < 11'd3) begin
      side_n = SW'(3);
    end else if (32'(grid_side_q) > MAX_SIDE) begin
      side_n = SW'(MAX_SIDE);
    end else begin
      side_n = SW'(grid_side_q);
    end
  end

  // Raster position of the next point
  always_comb begin
    col_wrap   = (32'(col_q) + 32'd1) >= 32'(side_n);
    last_d     = col_wrap && ((32'(row_q) + 32'd1) >= 32'(side_n));
    interior_d = (row_q >= CW'(2)) && (col_q != '0) && ((32'(col_q) + 32'd2) <= 32'(side_n));
    col_d      = col_wrap ? '0 : col_q + CW'(1);
    if (!col_wrap) begin
      row_d = row_q;
    end else if (last_d) begin
      row_d = '0;
    end else begin
      row_d = row_q + CW'(1);
    end
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Hold the accepted item for the rest of its pass
  always_ff @(posedge clk_i) begin
    if (accept) begin
      u_q        <= u_value_i;
      b_q        <= b_value_i;
      col_cur_q  <= col_q;
      par_q      <= row_q[0];
      interior_q <= interior_d;
      last_q     <= last_d;
    end
  end

  assign acc_stall = last_q && out_valid_q && !out_ready_i;

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_READ2;
      ST_READ2:  state_d = ST_SUM;
      ST_SUM:    state_d = ST_RES;
      ST_RES:    state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_ACC;
      ST_ACC:    if (!acc_stall) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer: outputs
  always_comb begin
    in_ready_o    = 1'b0;
    mem_we        = 1'b0;
    out_load      = 1'b0;
    ctrl          = '0;
    ctrl.interior = interior_q;
    // first read: centre and up; second read: left and right of the row above
    u_addr_a      = {~row_q[0], col_q};
    u_addr_b      = {row_q[0], col_q};
    b_addr        = col_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_READ2: begin
        ctrl.ld_first = 1'b1;
        u_addr_a      = {~par_q, col_cur_q - CW'(1)};
        u_addr_b      = {~par_q, col_cur_q + CW'(1)};
      end
      ST_SUM: begin
        ctrl.ld_sum = 1'b1;
        mem_we      = 1'b1;
      end
      ST_RES: begin
        ctrl.ld_res = 1'b1;
      end
      ST_SQUARE: begin
        ctrl.ld_sq = 1'b1;
      end
      ST_ACC: begin
        if (!acc_stall) begin
          ctrl.acc_en  = 1'b1;
          ctrl.acc_clr = last_q;
          out_load     = last_q;
        end
      end
      default: ;
    endcase
  end

  hsrn_line_store #(
    .CW (CW)
  ) u_store (
    .clk_i       (clk_i),
    .u_addr_a_i  (u_addr_a),
    .u_addr_b_i  (u_addr_b),
    .b_addr_i    (b_addr),
    .we_i        (mem_we),
    .u_waddr_i   ({par_q, col_cur_q}),
    .b_waddr_i   (col_cur_q),
    .u_wdata_i   (u_q),
    .b_wdata_i   (b_q),
    .u_rdata_a_o (u_rd_a),
    .u_rdata_b_o (u_rd_b),
    .b_rdata_o   (b_rd)
  );

  hsrn_residual u_residual (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .diag_i      (diag_q),
    .down_i      (u_q),
    .centre_rd_i (u_rd_a),
    .up_rd_i     (u_rd_b),
    .b_rd_i      (b_rd),
    .left_rd_i   (u_rd_a),
    .right_rd_i  (u_rd_b),
    .acc_next_o  (acc_next)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      l2_sum_q <= acc_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign l2_sum_o    = l2_sum_q;

endmodule
